/* rtl/rgb_box_filter_3x3_macros.svh */
// ============================================================================
// rgb_box_filter_3x3_macros.svh
// Assertion macros used by the checker of the RGB box filter.
// ============================================================================
`ifndef RGB_BOX_FILTER_3X3_MACROS_SVH
`define RGB_BOX_FILTER_3X3_MACROS_SVH

// Checked only while the block is out of reset.
`define RBF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every clock edge, reset included.
`define RBF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/rbf_pkg.sv */
// ============================================================================
// rbf_pkg
// Types and constants shared by the modules of the 3x3 RGB box filter.
// ============================================================================
package rbf_pkg;

    localparam int MAX_WIDTH_DEF = 2048;   // default line store depth
    localparam int DATA_W        = 8;      // bits per color channel
    localparam int CFG_W         = 12;     // width of the size registers
    localparam int ROW_W         = 13;     // row counter, holds height + 1
    localparam int POS_W         = 23;     // result counter within a frame
    localparam int SUM_W         = 12;     // sum of nine channel values
    localparam int APB_DW        = 32;
    localparam int APB_AW        = 3;
    localparam int REG_IDX_W     = 1;

    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd480;

    // floor(x / 9) == (x * 1821) >> 14 for every x below 2304.
    localparam int DIV9_MUL_W = 11;
    localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 11'd1821;
    localparam int DIV9_SHIFT = 14;

    typedef logic [DATA_W-1:0] chan_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } pixel_t;

    // Index 0 is the upper row, 2 the current row.
    typedef pixel_t [2:0] column_t;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } sums_t;

    typedef struct packed {
        logic has_res;
        logic border;
        logic frame_end;
    } item_ctrl_t;

endpackage

/* rtl/rbf_ram.sv */
// ============================================================================
// rbf_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ============================================================================
module rbf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/rbf_cfg.sv */
// ============================================================================
// rbf_cfg
// APB register file holding the frame size, with the effective size decode.
// ============================================================================
module rbf_cfg
    import rbf_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [APB_AW-1:0]                paddr,
    input  logic [APB_DW-1:0]                pwdata,
    output logic [APB_DW-1:0]                prdata,
    output logic [$clog2(MAX_WIDTH+1)-1:0]   width_eff,
    output logic [CFG_W-1:0]                 height_eff
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int XW = (WW > CFG_W) ? WW : CFG_W;

    logic [CFG_W-1:0]     width_reg;
    logic [CFG_W-1:0]     height_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_stb;

    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_stb  = psel && penable && pwrite;

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
        end else if (wr_stb) begin
            unique case (reg_idx)
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DW'(width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(height_reg);
            default:          prdata = '0;
        endcase
    end

    // Width is clamped to the line store depth, both sizes to at least one.
    always_comb begin
        if (width_reg == '0) begin
            width_eff = WW'(1);
        end else if (XW'(width_reg) > XW'(MAX_WIDTH)) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = WW'(width_reg);
        end
    end

    assign height_eff = (height_reg == '0) ? CFG_W'(1) : height_reg;

endmodule

/* rtl/rbf_pos.sv */
// ============================================================================
// rbf_pos
// Frame position counters and the per-item result, border and end decode.
// ============================================================================
module rbf_pos
    import rbf_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]  width_eff,
    input  logic [CFG_W-1:0]                height_eff,
    output logic [$clog2(MAX_WIDTH)-1:0]    col,
    output item_ctrl_t                      ctrl
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int PW = WW + CFG_W;
    localparam int EW = (PW > POS_W) ? PW : POS_W;

    logic [CW-1:0]    col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [POS_W-1:0] pos_reg;

    logic [ROW_W-1:0] hgt;
    logic [WW-1:0]    col_inc;
    logic [ROW_W-1:0] orow;
    logic [WW-1:0]    ocol;
    logic [PW-1:0]    frame_size;
    logic             frame_last;

    assign hgt     = ROW_W'(height_eff);
    assign col_inc = WW'(col_reg) + WW'(1);

    // At column zero the result belongs to the last column of two rows up.
    assign orow = (col_reg != '0) ? row_reg - ROW_W'(1) : row_reg - ROW_W'(2);
    assign ocol = (col_reg != '0) ? WW'(col_reg) - WW'(1) : width_eff - WW'(1);

    assign frame_size = PW'(width_eff) * PW'(height_eff);
    assign frame_last = row_reg >= hgt + ROW_W'(1);

    always_comb begin
        ctrl.has_res   = (row_reg >= ROW_W'(2)) ||
                         ((row_reg == ROW_W'(1)) && (col_reg != '0));
        ctrl.border    = (orow == '0) || (ocol == '0) ||
                         (orow >= hgt - ROW_W'(1)) || (ocol >= width_eff - WW'(1));
        ctrl.frame_end = EW'(pos_reg) == EW'(frame_size) - EW'(1);
    end

    assign col = col_reg;

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            col_reg <= '0;
            row_reg <= '0;
            pos_reg <= '0;
        end else if (step) begin
            if (frame_last) begin
                col_reg <= '0;
                row_reg <= '0;
                pos_reg <= '0;
            end else begin
                pos_reg <= pos_reg + POS_W'(ctrl.has_res);
                if (col_inc >= width_eff) begin
                    col_reg <= '0;
                    row_reg <= row_reg + ROW_W'(1);
                end else begin
                    col_reg <= col_reg + CW'(1);
                end
            end
        end
    end

endmodule

/* rtl/rbf_win.sv */
// ============================================================================
// rbf_win
// 3x3 pixel window and the registered per-channel sums of its nine pixels.
// ============================================================================
module rbf_win
    import rbf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    shift_en,
    input  column_t col_in,
    input  logic    sum_en,
    output sums_t   sums,
    output pixel_t  center
);

    column_t win_reg [3];

    logic [SUM_W-1:0] col_r [3];
    logic [SUM_W-1:0] col_g [3];
    logic [SUM_W-1:0] col_b [3];

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            for (int k = 0; k < 3; k++) begin
                win_reg[k] <= '0;
            end
        end else if (shift_en) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= col_in;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            col_r[k] = SUM_W'(win_reg[k][0].red) + SUM_W'(win_reg[k][1].red) +
                       SUM_W'(win_reg[k][2].red);
            col_g[k] = SUM_W'(win_reg[k][0].green) + SUM_W'(win_reg[k][1].green) +
                       SUM_W'(win_reg[k][2].green);
            col_b[k] = SUM_W'(win_reg[k][0].blue) + SUM_W'(win_reg[k][1].blue) +
                       SUM_W'(win_reg[k][2].blue);
        end
    end

    always_ff @(posedge clk) begin
        if (sum_en) begin
            sums.red   <= col_r[0] + col_r[1] + col_r[2];
            sums.green <= col_g[0] + col_g[1] + col_g[2];
            sums.blue  <= col_b[0] + col_b[1] + col_b[2];
            center     <= win_reg[1][1];
        end
    end

endmodule

/* rtl/rbf_mean.sv */
// ============================================================================
// rbf_mean
// Division of the window sums by nine and the result pixel register.
// ============================================================================
module rbf_mean
    import rbf_pkg::*;
(
    input  logic   clk,
    input  logic   en,
    input  sums_t  sums,
    input  pixel_t center,
    input  logic   border,
    output pixel_t result
);

    localparam int MUL_W = SUM_W + DIV9_MUL_W;

    function automatic chan_t div9(input logic [SUM_W-1:0] x);
        logic [MUL_W-1:0] prod;
        prod = MUL_W'(x) * MUL_W'(DIV9_MUL);
        return chan_t'(prod >> DIV9_SHIFT);
    endfunction

    always_ff @(posedge clk) begin
        if (en) begin
            if (border) begin
                result <= center;
            end else begin
                result.red   <= div9(sums.red);
                result.green <= div9(sums.green);
                result.blue  <= div9(sums.blue);
            end
        end
    end

endmodule

/* rtl/rgb_box_filter_3x3.sv */
// ============================================================================
// rgb_box_filter_3x3
// Streaming 3x3 per-channel mean filter for RGB888 pixels in raster order.
// Pipeline: the item that completes a window is registered in s1 with the
// line store reads, shifted into the window in s2, summed in s3 and divided
// by nine into the output register; that item comes one row plus one pixel
// after the pixel. Throughput: one item per cycle unless the sink stalls,
// set by one read and one write per cycle on each of the two line store RAMs.
// Reset: synchronous, active low; clears counters, window, pipeline valids and
// restores the size registers. The line stores are not cleared.
// ============================================================================
module rgb_box_filter_3x3
    import rbf_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_action,
    input  logic [7:0]        s_in_red,
    input  logic [7:0]        s_in_green,
    input  logic [7:0]        s_in_blue,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_red,
    output logic [7:0]        m_out_green,
    output logic [7:0]        m_out_blue,
    output logic              m_frame_end,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int PIX_W = $bits(pixel_t);

    logic [WW-1:0]    width_eff;
    logic [CFG_W-1:0] height_eff;
    logic [CW-1:0]    col;
    item_ctrl_t       ctrl;

    logic   accept, adv1, adv2, adv3;
    pixel_t pix_in;
    pixel_t up_rd, mid_rd, up_eff;

    logic       s1_valid_reg, s2_valid_reg, s3_valid_reg, m_valid_reg;
    pixel_t     s1_pix_reg, s1_byp_reg;
    logic       s1_hit_reg;
    logic [CW-1:0] s1_col_reg;
    item_ctrl_t s1_ctrl_reg, s2_ctrl_reg, s3_ctrl_reg;
    logic       m_frame_end_reg;

    column_t win_col;
    sums_t   sums;
    pixel_t  center;
    pixel_t  result;

    assign pready = 1'b1;

    rbf_cfg #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
        .clk        (aclk),
        .rst_n      (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .width_eff  (width_eff),
        .height_eff (height_eff)
    );

    rbf_pos #(.MAX_WIDTH(MAX_WIDTH)) u_pos (
        .clk        (aclk),
        .rst_n      (aresetn),
        .step       (accept),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .col        (col),
        .ctrl       (ctrl)
    );

    // Each stage moves when the next one is empty or moving too.
    assign adv3    = s3_valid_reg && (!m_valid_reg || m_ready);
    assign adv2    = s2_valid_reg && (!s3_valid_reg || adv3);
    assign adv1    = s1_valid_reg && (!s2_valid_reg || adv2);
    assign s_ready = !s1_valid_reg || adv1;
    assign accept  = s_valid && s_ready;

    // A drain tick enters the window as a black pixel.
    assign pix_in = s_action ? '0 : pixel_t'({s_in_red, s_in_green, s_in_blue});

    // The middle row is written on accept; the upper row gets the old middle
    // value once it has been read, when the item leaves the first stage.
    rbf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_ram (
        .clk     (aclk),
        .wr_en   (accept),
        .wr_addr (col),
        .wr_data (pix_in),
        .rd_en   (accept),
        .rd_addr (col),
        .rd_data (mid_rd)
    );

    rbf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_up_ram (
        .clk     (aclk),
        .wr_en   (adv1),
        .wr_addr (s1_col_reg),
        .wr_data (mid_rd),
        .rd_en   (accept),
        .rd_addr (col),
        .rd_data (up_rd)
    );

    // A read of the upper row at the address being written in the same cycle
    // takes the written value.
    assign up_eff = s1_hit_reg ? s1_byp_reg : up_rd;

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg  <= pix_in;
            s1_ctrl_reg <= ctrl;
            s1_col_reg  <= col;
            s1_hit_reg  <= s1_valid_reg && (col == s1_col_reg);
            s1_byp_reg  <= mid_rd;
        end
        if (adv1) begin
            s2_ctrl_reg <= s1_ctrl_reg;
        end
        if (adv2) begin
            s3_ctrl_reg <= s2_ctrl_reg;
        end
        if (adv3) begin
            m_frame_end_reg <= s3_ctrl_reg.frame_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (adv1) begin
                s1_valid_reg <= 1'b0;
            end
            if (adv1) begin
                s2_valid_reg <= 1'b1;
            end else if (adv2) begin
                s2_valid_reg <= 1'b0;
            end
            if (adv2) begin
                s3_valid_reg <= 1'b1;
            end else if (adv3) begin
                s3_valid_reg <= 1'b0;
            end
            if (adv3) begin
                m_valid_reg <= s3_ctrl_reg.has_res;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign win_col[0] = up_eff;
    assign win_col[1] = mid_rd;
    assign win_col[2] = s1_pix_reg;

    rbf_win u_win (
        .clk      (aclk),
        .rst_n    (aresetn),
        .shift_en (adv1),
        .col_in   (win_col),
        .sum_en   (adv2),
        .sums     (sums),
        .center   (center)
    );

    rbf_mean u_mean (
        .clk    (aclk),
        .en     (adv3),
        .sums   (sums),
        .center (center),
        .border (s3_ctrl_reg.border),
        .result (result)
    );

    assign m_valid     = m_valid_reg;
    assign m_out_red   = result.red;
    assign m_out_green = result.green;
    assign m_out_blue  = result.blue;
    assign m_frame_end = m_frame_end_reg;

endmodule

/* rtl/rbf_checker.sv */
// ============================================================================
// rbf_checker
// Port-level checks of the RGB box filter, bound to its top level.
// ============================================================================
`include "rgb_box_filter_3x3_macros.svh"

module rbf_checker
    import rbf_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [7:0]        m_out_red,
    input logic [7:0]        m_out_green,
    input logic [7:0]        m_out_blue,
    input logic              m_frame_end,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [APB_AW-1:0] paddr,
    input logic [APB_DW-1:0] pwdata,
    input logic [APB_DW-1:0] prdata
);

    // A result held back by the sink keeps its value.
    `RBF_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_out_red) && $stable(m_out_green) && $stable(m_out_blue) && $stable(m_frame_end), "stalled result changed")

    // The input side only stalls behind a result that the sink refuses.
    `RBF_ASSERT(a_stall_cause, aclk, aresetn, !s_ready |-> m_valid && !m_ready, "input stalled without output backpressure")

    // Reset empties the output register.
    `RBF_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")

    // A width write reads back on the next cycle.
    `RBF_ASSERT(a_width_readback, aclk, aresetn, (psel && penable && pwrite && !paddr[2]) ##1 (!paddr[2] && aresetn) |-> prdata[11:0] == $past(pwdata[11:0]) && prdata[31:12] == 20'd0, "width register readback mismatch")

endmodule

bind rgb_box_filter_3x3 rbf_checker u_rbf_checker (.*);
